>>> rtl/sfce_pkg.sv
package sfce_pkg;

	// Command codes seen on the first byte of a transaction.
	localparam logic [7:0] CMD_READ   = 8'h03;
	localparam logic [7:0] CMD_WRDIS  = 8'h04;
	localparam logic [7:0] CMD_STATUS = 8'h05;
	localparam logic [7:0] CMD_WREN   = 8'h06;
	localparam logic [7:0] CMD_PAGEWR = 8'h0A;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_MASK  = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_ORDER = 1'd1;

	localparam logic [23:0] SIZE_MASK_RESET = 24'h03FFFF;
	localparam logic [1:0]  ADDR_LAST_POS   = 2'd2;
	localparam logic [1:0]  DATA_POS        = 2'd3;

	// Queue depths between the parts of the block.
	localparam int OPQ_DEPTH  = 4;
	localparam int OUTQ_DEPTH = 4;
	localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

	// Operations handed from the front part to the back part.
	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ,
		OP_WRITE,
		OP_STATUS
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [23:0] addr;
		logic [7:0]  data;
	} op_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       store_dirty;
	} result_t;

endpackage

>>> rtl/sfce_ram.sv
module sfce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/sfce_fifo.sv
module sfce_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Storage; the depth is a power of two so the pointers wrap on their own.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

>>> rtl/sfce_front.sv
module sfce_front
	import sfce_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic [7:0]             spi_byte,
	input  logic                   next_select,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [23:0]            cfg_data,
	output logic                   op_push,
	output op_t                    op
);

	logic        size_msb_q;
	logic [23:0] size_mask_q;
	logic        selected_q;
	logic [7:0]  command_q;
	logic [1:0]  pos_q;
	logic [23:0] addr_bytes_q;
	logic [23:0] cur_addr_q;
	logic        wr_en_q;

	logic [1:0]  pos_n;
	logic [7:0]  command_n;
	logic [23:0] addr_bytes_n;
	logic [23:0] cur_addr_n;
	logic        wr_en_n;
	logic [23:0] addr_asm;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_mask_q <= SIZE_MASK_RESET;
			size_msb_q  <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_SIZE_MASK:  size_mask_q <= cfg_data;
				CFG_ADDR_ORDER: size_msb_q  <= cfg_data[0];
			endcase
		end
	end

	// Command decode and address tracking for one accepted byte.
	always_comb begin
		command_n    = command_q;
		pos_n        = pos_q;
		addr_bytes_n = addr_bytes_q;
		cur_addr_n   = cur_addr_q;
		wr_en_n      = wr_en_q;
		addr_asm     = '0;
		op.kind      = OP_NONE;
		op.addr      = cur_addr_q;
		op.data      = spi_byte;

		if (!selected_q) begin
			command_n = spi_byte;
			pos_n     = '0;
		end else begin
			unique case (command_q)
				CMD_READ, CMD_PAGEWR: begin
					if (pos_q != DATA_POS) begin
						// Collect one address byte.
						addr_bytes_n[{pos_q, 3'b000} +: 8] = spi_byte;
						pos_n = pos_q + 2'd1;
						addr_asm = size_msb_q ?
							{addr_bytes_n[7:0], addr_bytes_n[15:8], addr_bytes_n[23:16]} :
							addr_bytes_n;
						if (pos_q == ADDR_LAST_POS) begin
							cur_addr_n = addr_asm & size_mask_q;
						end
					end else if (command_q == CMD_READ) begin
						// Read wraps over the whole size.
						op.kind    = OP_READ;
						cur_addr_n = (cur_addr_q + 24'd1) & size_mask_q;
					end else begin
						// Page write wraps within its 256-byte page.
						op.kind    = OP_WRITE;
						cur_addr_n = {cur_addr_q[23:8], cur_addr_q[7:0] + 8'd1};
					end
				end
				CMD_WREN:  wr_en_n = 1'b1;
				CMD_WRDIS: wr_en_n = 1'b0;
				CMD_STATUS: begin
					op.kind = OP_STATUS;
					op.data = {6'b0, wr_en_q, 1'b0};
				end
				default: ;
			endcase
		end
	end

	// Every accepted byte yields exactly one operation.
	assign op_push = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			selected_q   <= 1'b0;
			command_q    <= '0;
			pos_q        <= '0;
			addr_bytes_q <= '0;
			cur_addr_q   <= '0;
			wr_en_q      <= 1'b0;
		end else if (take) begin
			selected_q   <= next_select;
			command_q    <= command_n;
			pos_q        <= pos_n;
			addr_bytes_q <= addr_bytes_n;
			cur_addr_q   <= cur_addr_n;
			wr_en_q      <= wr_en_n;
		end
	end

endmodule

>>> rtl/sfce_back.sv
module sfce_back
	import sfce_pkg::*;
#(
	parameter int ADDR_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  opq_empty,
	input  op_t                   opq_head,
	output logic                  opq_pop,
	input  logic [OUTQ_CNT_W-1:0] out_count,
	output logic                  out_push,
	output result_t               out_item,
	output logic                  clearing
);

	localparam int DEPTH = 1 << ADDR_BITS;

	logic                 clear_q;
	logic [ADDR_BITS-1:0] clear_addr_q;
	logic                 valid_s1;
	op_kind_t             kind_s1;
	logic [7:0]           data_s1;
	logic [7:0]           out_byte_q;
	logic                 dirty_q;

	logic                 room;
	logic                 issue;
	logic                 ram_we;
	logic [ADDR_BITS-1:0] ram_addr;
	logic [7:0]           ram_wdata;
	logic [7:0]           ram_rdata;
	logic [7:0]           out_byte_n;
	logic [OUTQ_CNT_W:0]  out_used;

	// Reserve a result slot for the operation already in flight.
	assign out_used = {1'b0, out_count} + (OUTQ_CNT_W+1)'(valid_s1);
	assign room     = out_used < (OUTQ_CNT_W+1)'(OUTQ_DEPTH);
	assign issue    = !clear_q && !opq_empty && room;
	assign opq_pop  = issue;
	assign clearing = clear_q;

	// Store port: clearing pass after reset, then one operation per cycle while the result queue has room.
	assign ram_we    = clear_q || (issue && opq_head.kind == OP_WRITE);
	assign ram_addr  = clear_q ? clear_addr_q : opq_head.addr[ADDR_BITS-1:0];
	assign ram_wdata = clear_q ? 8'd0 : opq_head.data;

	sfce_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Clearing pass over the whole store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q      <= 1'b1;
			clear_addr_q <= '0;
		end else if (clear_q) begin
			clear_addr_q <= clear_addr_q + ADDR_BITS'(1);
			if (clear_addr_q == '1) begin
				clear_q <= 1'b0;
			end
		end
	end

	// Stage 1 waits for the registered read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1 <= opq_head.kind;
			data_s1 <= opq_head.data;
		end
	end

	// The held output byte changes on reads and status loads.
	always_comb begin
		out_byte_n = out_byte_q;
		if (kind_s1 == OP_READ) begin
			out_byte_n = ram_rdata;
		end else if (kind_s1 == OP_STATUS) begin
			out_byte_n = data_s1;
		end
	end

	assign out_push             = valid_s1;
	assign out_item.out_byte    = out_byte_n;
	assign out_item.store_dirty = dirty_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_byte_q <= '0;
			dirty_q    <= 1'b0;
		end else begin
			if (valid_s1) begin
				out_byte_q <= out_byte_n;
			end
			if (issue && opq_head.kind == OP_WRITE) begin
				dirty_q <= 1'b1;
			end
		end
	end

	// No operation may reach the store while it is being cleared.
	a_no_issue_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> !clear_q)
		else $error("operation issued during clearing pass");

	// A result leaving stage 1 always finds a free slot.
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (out_count < OUTQ_CNT_W'(OUTQ_DEPTH)))
		else $error("result queue overflow");

	// The clearing pass ends only after the last entry.
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clear_q) |-> ($past(clear_addr_q) == '1))
		else $error("clearing pass ended early");

endmodule

>>> rtl/spi_flash_command_engine_core.sv
// Device side of a serial flash command interface.
// Input queue port: each transaction carries one byte from the host (spi_byte)
// and the chip-select level that holds after it (next_select). A byte taken
// while deselected becomes the command; later bytes are handled by it.
// Result queue port: every input transaction yields exactly one result with the
// held output byte (read data or status) and the store dirty mark.
// Configuration: cfg_write with cfg_index and cfg_data sets the size mask
// (index 0) or the address byte order (index 1); write only while idle.
// Throughput is one byte per cycle while neither queue is full and the store is
// not being cleared: the front decoder takes one byte a cycle and the back part
// does one store access a cycle on a single-port memory. From input acceptance
// to the result showing, an item passes the operation queue and the registered
// store read; the result shows as soon as it enters the result queue. When pop
// is held low the result queue fills, the back part stops issuing, the operation
// queue fills and full rises. After reset the store is cleared one byte a cycle
// over all 2^ADDR_BITS bytes, and full stays high until that pass is done.
module spi_flash_command_engine_core
	import sfce_pkg::*;
#(
	parameter int ADDR_BITS = 18
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic [7:0]             spi_byte,
	input  logic                   next_select,
	output logic                   empty,
	input  logic                   pop,
	output logic [7:0]             out_byte,
	output logic                   store_dirty,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [23:0]            cfg_data
);

	localparam int OP_W  = $bits(op_t);
	localparam int RES_W = $bits(result_t);

	logic                         take;
	logic                         op_push;
	op_t                          op;
	logic                         opq_full;
	logic                         opq_empty;
	logic                         opq_pop;
	logic [OP_W-1:0]              opq_rdata;
	op_t                          opq_head;
	logic [$clog2(OPQ_DEPTH+1)-1:0] opq_count;
	logic                         clearing;
	logic                         out_push;
	result_t                      out_item;
	logic [RES_W-1:0]             outq_rdata;
	result_t                      out_head;
	logic                         outq_full;
	logic [OUTQ_CNT_W-1:0]        out_count;

	// Input side stalls on a full operation queue or during the clearing pass.
	assign full = opq_full || clearing;
	assign take = push && !full;

	sfce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.spi_byte   (spi_byte),
		.next_select(next_select),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op_push    (op_push),
		.op         (op)
	);

	// Operation queue between the front and back parts.
	sfce_fifo #(
		.WIDTH(OP_W),
		.DEPTH(OPQ_DEPTH)
	) u_opq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (op_push),
		.wdata (op),
		.full  (opq_full),
		.pop   (opq_pop),
		.rdata (opq_rdata),
		.empty (opq_empty),
		.count (opq_count)
	);

	assign opq_head = opq_rdata;

	sfce_back #(
		.ADDR_BITS(ADDR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.opq_empty(opq_empty),
		.opq_head (opq_head),
		.opq_pop  (opq_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_item (out_item),
		.clearing (clearing)
	);

	// Result queue toward the host side.
	sfce_fifo #(
		.WIDTH(RES_W),
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_item),
		.full  (outq_full),
		.pop   (pop),
		.rdata (outq_rdata),
		.empty (empty),
		.count (out_count)
	);

	assign out_head    = outq_rdata;
	assign out_byte    = out_head.out_byte;
	assign store_dirty = out_head.store_dirty;

	// The operation queue never holds more than its depth.
	a_opq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		opq_count <= ($clog2(OPQ_DEPTH+1))'(OPQ_DEPTH))
		else $error("operation queue count out of range");

	// The back part never pushes into a full result queue.
	a_outq_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !outq_full)
		else $error("result dropped at full result queue");

	// No byte is taken while the store is being cleared.
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !take)
		else $error("input accepted during clearing pass");

endmodule

>>> tb/spi_flash_command_engine_core_tb.sv
`timescale 1ns / 1ps

module spi_flash_command_engine_core_tb
	import sfce_pkg::*;
;

	localparam int STORE_BITS  = 18;
	localparam int STORE_DEPTH = 1 << STORE_BITS;

	typedef struct {
		logic [7:0] data;
		logic       sel;
	} spi_xfer_t;

	// Block ports; every input starts at a known value.
	logic                   clk;
	logic                   arst_n      = 1'b0;
	logic                   push        = 1'b0;
	logic                   full;
	logic [7:0]             spi_byte    = 8'h00;
	logic                   next_select = 1'b0;
	logic                   empty;
	logic                   pop         = 1'b0;
	logic [7:0]             out_byte;
	logic                   store_dirty;
	logic                   cfg_write   = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index   = CFG_SIZE_MASK;
	logic [23:0]            cfg_data    = 24'h0;

	// Transfers waiting to be sent and replies waiting to be seen.
	spi_xfer_t bytes_to_send[$];
	result_t   replies_due[$];
	int        fail_count  = 0;
	int        phase_items = 0;
	logic      gen_selected = 1'b0;
	int        calm_left[2] = '{0, 0};
	int        send_gap = 0;
	int        pop_gap  = 0;
	spi_xfer_t next_xfer;

	// Local copy of the flash device state and its configuration.
	logic [23:0] cfg_size_mask = SIZE_MASK_RESET;
	logic        cfg_msb_first = 1'b0;
	logic        flash_selected   = 1'b0;
	logic [7:0]  flash_cmd        = 8'h00;
	logic [1:0]  flash_pos        = 2'd0;
	logic [23:0] flash_addr_bytes = 24'h0;
	logic [23:0] flash_cur_addr   = 24'h0;
	logic        flash_wren       = 1'b0;
	logic [7:0]  flash_out        = 8'h00;
	logic        flash_dirty      = 1'b0;
	bit   [7:0]  flash_mem [0:STORE_DEPTH-1];

	spi_flash_command_engine_core #(
		.ADDR_BITS(STORE_BITS)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.spi_byte   (spi_byte),
		.next_select(next_select),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.store_dirty(store_dirty),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Gap length for one side: mostly none, some short, a few long, with calm stretches.
	function automatic int pick_gap(int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4)
			calm_left[side] = $urandom_range(20, 80);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one accepted byte to the device state and queue the reply it yields.
	task automatic compute_spi_reply(input logic [7:0] b, input logic sel_after);
		result_t     reply;
		logic [23:0] addr;
		if (!flash_selected) begin
			flash_cmd = b;
			flash_pos = 2'd0;
		end else if ((flash_cmd == CMD_READ || flash_cmd == CMD_PAGEWR) &&
				flash_pos != DATA_POS) begin
			// Address phase: gather three bytes, then form the start address.
			flash_addr_bytes[8*flash_pos +: 8] = b;
			flash_pos = flash_pos + 2'd1;
			if (flash_pos == DATA_POS) begin
				addr = flash_addr_bytes;
				if (cfg_msb_first)
					addr = {flash_addr_bytes[7:0], flash_addr_bytes[15:8],
						flash_addr_bytes[23:16]};
				flash_cur_addr = addr & cfg_size_mask;
			end
		end else begin
			case (flash_cmd)
				CMD_READ: begin
					flash_out = flash_mem[flash_cur_addr[STORE_BITS-1:0]];
					flash_cur_addr = (flash_cur_addr + 24'd1) & cfg_size_mask;
				end
				CMD_PAGEWR: begin
					// Page write wraps in the low byte only.
					flash_mem[flash_cur_addr[STORE_BITS-1:0]] = b;
					flash_cur_addr[7:0] = flash_cur_addr[7:0] + 8'd1;
					flash_dirty = 1'b1;
				end
				CMD_WREN:   flash_wren = 1'b1;
				CMD_WRDIS:  flash_wren = 1'b0;
				CMD_STATUS: flash_out = {6'b0, flash_wren, 1'b0};
				default: ;
			endcase
		end
		flash_selected = sel_after;
		reply.out_byte    = flash_out;
		reply.store_dirty = flash_dirty;
		replies_due.push_back(reply);
	endtask

	task automatic add_item(input logic [7:0] b, input logic sel);
		spi_xfer_t x;
		x.data = b;
		x.sel  = sel;
		bytes_to_send.push_back(x);
		gen_selected = sel;
		phase_items++;
	endtask

	// One random transaction: mostly well-formed commands, some noise and cut-off ones.
	task automatic gen_transaction();
		int          r;
		int          n;
		logic [7:0]  cmd;
		logic [15:0] page;
		logic [23:0] a;
		logic [7:0]  abyte [3];
		r = $urandom_range(0, 99);
		if (r < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) add_item(8'($urandom), 1'($urandom_range(0, 1)));
			return;
		end
		// Close a transaction that noise left open, so the next byte is a command.
		if (gen_selected)
			add_item(8'($urandom), 1'b0);
		if (r < 42)
			cmd = CMD_READ;
		else if (r < 72)
			cmd = CMD_PAGEWR;
		else if (r < 77)
			cmd = CMD_WREN;
		else if (r < 82)
			cmd = CMD_WRDIS;
		else if (r < 92)
			cmd = CMD_STATUS;
		else
			cmd = 8'($urandom);
		add_item(cmd, 1'b1);
		if (cmd == CMD_READ || cmd == CMD_PAGEWR) begin
			// A few pages are reused so that reads find written data.
			case ($urandom_range(0, 5))
				0: page = 16'h0000;
				1: page = 16'h0001;
				2: page = 16'h03FF;
				3: page = 16'h0400;
				4: page = 16'hFFFF;
				default: page = 16'($urandom);
			endcase
			a = {page, 8'($urandom)};
			if (cfg_msb_first)
				abyte = '{a[23:16], a[15:8], a[7:0]};
			else
				abyte = '{a[7:0], a[15:8], a[23:16]};
			if ($urandom_range(0, 99) < 8) begin
				// Chip select drops during the address phase.
				n = $urandom_range(0, 2);
				for (int i = 0; i <= n; i++)
					add_item(abyte[i], i != n);
				return;
			end
			n = ($urandom_range(0, 99) < 3) ? $urandom_range(250, 270) : $urandom_range(0, 10);
			for (int i = 0; i < 3; i++)
				add_item(abyte[i], !(i == 2 && n == 0));
			for (int i = 0; i < n; i++)
				add_item(8'($urandom), i != n - 1);
		end else begin
			n = $urandom_range(1, 4);
			for (int i = 0; i < n; i++)
				add_item(8'($urandom), i != n - 1);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_config(input logic [23:0] mask, input logic msb_first);
		write_reg(CFG_SIZE_MASK, mask);
		write_reg(CFG_ADDR_ORDER, {23'b0, msb_first});
		cfg_size_mask = mask;
		cfg_msb_first = msb_first;
	endtask

	task automatic wait_drained();
		while (bytes_to_send.size() > 0 || push || replies_due.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_phase(input logic [23:0] mask, input logic msb_first);
		set_config(mask, msb_first);
		phase_items = 0;
		while (phase_items < 140)
			gen_transaction();
		wait_drained();
	endtask

	// Driver: sends queued transfers, holding each one while full is high.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push <= 1'b0;
			send_gap = 0;
		end else begin
			if (push && !full)
				compute_spi_reply(spi_byte, next_select);
			if (!push || !full) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (bytes_to_send.size() > 0) begin
					next_xfer = bytes_to_send.pop_front();
					spi_byte    <= next_xfer.data;
					next_select <= next_xfer.sel;
					push        <= 1'b1;
					send_gap = pick_gap(0);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each popped result against the oldest pending reply.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_gap = 0;
		end else begin
			if (pop && !empty) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual out_byte %02h store_dirty %0b",
						$time, out_byte, store_dirty);
					fail_count++;
				end else begin
					if (replies_due[0].out_byte !== out_byte) begin
						$display("%0t: out_byte mismatch, expected %02h, actual %02h",
							$time, replies_due[0].out_byte, out_byte);
						fail_count++;
					end
					if (replies_due[0].store_dirty !== store_dirty) begin
						$display("%0t: store_dirty mismatch, expected %0b, actual %0b",
							$time, replies_due[0].store_dirty, store_dirty);
						fail_count++;
					end
					void'(replies_due.pop_front());
				end
			end
			if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				pop_gap = pick_gap(1);
			end
		end
	end

	// Main sequence: reset, directed transactions, then random phases over several settings.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		set_config(SIZE_MASK_RESET, 1'b0);

		// Status with write-enable clear, then set, then status over several bytes.
		add_item(CMD_STATUS, 1'b1);
		add_item(8'hFF, 1'b0);
		add_item(CMD_WREN, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(CMD_STATUS, 1'b1);
		add_item(8'h00, 1'b1);
		add_item(8'hFF, 1'b0);
		// Page write across the end of the last page, wrapping inside it.
		add_item(CMD_PAGEWR, 1'b1);
		add_item(8'hFE, 1'b1);
		add_item(8'hFF, 1'b1);
		add_item(8'h03, 1'b1);
		add_item(8'h00, 1'b1);
		add_item(8'hFF, 1'b1);
		add_item(8'h5A, 1'b0);
		// Read across the top of the size mask, wrapping to zero.
		add_item(CMD_READ, 1'b1);
		add_item(8'hFE, 1'b1);
		add_item(8'hFF, 1'b1);
		add_item(8'h03, 1'b1);
		add_item(8'h00, 1'b1);
		add_item(8'h00, 1'b1);
		add_item(8'h00, 1'b0);
		add_item(CMD_WRDIS, 1'b1);
		add_item(8'hAA, 1'b0);
		// Zero and unknown commands leave the state alone.
		add_item(8'h00, 1'b1);
		add_item(8'hFF, 1'b0);
		add_item(8'hFF, 1'b1);
		add_item(8'h77, 1'b0);
		add_item(CMD_STATUS, 1'b0);
		wait_drained();

		run_phase(24'hFFFFFF, 1'b1);
		run_phase(24'h000000, 1'b0);
		run_phase(24'h0000FF, 1'b1);
		run_phase(24'($urandom), 1'($urandom_range(0, 1)));
		run_phase(SIZE_MASK_RESET, 1'b1);
		run_phase(24'h01FFFF, 1'b0);

		if (fail_count == 0)
			$display("** spi_flash_command_engine_core: PASSED **");
		else
			$display("** spi_flash_command_engine_core: FAILED **");
		$finish;
	end

	// Run limit, covering the store clearing pass after reset.
	initial begin
		#20_000_000;
		$display("** spi_flash_command_engine_core: FAILED **");
		$finish;
	end

endmodule

>>> files.f
rtl/sfce_pkg.sv
rtl/sfce_ram.sv
rtl/sfce_fifo.sv
rtl/sfce_front.sv
rtl/sfce_back.sv
rtl/spi_flash_command_engine_core.sv
tb/spi_flash_command_engine_core_tb.sv
